// ===== src/sefr_pkg.sv =====
`default_nettype none
package sefr_pkg;

  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_ENQ = 8'h05;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] CODE_ESC = 8'h1b;

  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ACK,
    OP_CLOSE
  } op_t;

  // command from the front to the back, per byte that causes results
  typedef struct packed {
    logic pre_nak;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic close_done;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_ACT,
    S_SUM_RD,
    S_SUM_AC,
    S_NAK,
    S_OUT_RD,
    S_OUT_WR
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/sefr_ram.sv =====
`default_nettype none
module sefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sefr_fifo.sv =====
`default_nettype none
module sefr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== src/sefr_front.sv =====
`default_nettype none
module sefr_front #(
  parameter int FRAME_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  cq_push,
  output sefr_pkg::cmd_t                        cq_cmd,
  output logic      [$clog2(FRAME_DEPTH+1)-1:0] cq_len,
  input  wire logic                             cq_full,
  output logic                                  ram_we,
  output logic      [$clog2(FRAME_DEPTH)-1:0]   ram_waddr,
  output logic      [7:0]                       ram_wdata,
  input  wire sefr_pkg::back_stat_t             bstat
);

  import sefr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic          esc_r, esc_nxt;
  logic          inside_r, inside_nxt;
  logic          close_wait_r, close_wait_nxt;

  logic          accept;
  logic          ovf;
  logic [CW-1:0] fill_v;
  logic          inside_v;
  logic          is_ctl;
  logic          do_store;
  op_t           op;

  // a closing frame reads the buffer, so no new byte until the check is over
  assign full   = cq_full || close_wait_r;
  assign accept = push && !full;

  always_comb begin
    ovf      = (fill_r >= CW'(FRAME_DEPTH));
    fill_v   = ovf ? '0 : fill_r;
    inside_v = ovf ? 1'b0 : inside_r;
    is_ctl   = (rx_byte == CODE_STX) || (rx_byte == CODE_ETX) ||
               (rx_byte == CODE_ENQ) || (rx_byte == CODE_ESC);
    do_store = is_ctl ? esc_r : inside_v;
    op       = OP_NONE;

    fill_nxt       = fill_r;
    esc_nxt        = esc_r;
    inside_nxt     = inside_r;
    close_wait_nxt = close_wait_r;

    if (accept) begin
      fill_nxt   = fill_v;
      inside_nxt = inside_v;
      if (do_store) begin
        fill_nxt = fill_v + CW'(1);
      end
      if (is_ctl && esc_r) begin
        esc_nxt = 1'b0;
      end else if (is_ctl) begin
        case (rx_byte)
          CODE_ENQ: begin
            inside_nxt = 1'b0;
            fill_nxt   = '0;
            op         = OP_ACK;
          end
          CODE_STX: begin
            inside_nxt = 1'b1;
            fill_nxt   = '0;
          end
          CODE_ESC: begin
            esc_nxt = 1'b1;
          end
          default: begin
            inside_nxt     = 1'b0;
            op             = OP_CLOSE;
            close_wait_nxt = 1'b1;
          end
        endcase
      end
    end
    if (bstat.close_done) begin
      close_wait_nxt = 1'b0;
    end
  end

  assign cq_push        = accept && (ovf || (op != OP_NONE));
  assign cq_cmd.pre_nak = ovf;
  assign cq_cmd.op      = op;
  assign cq_len         = fill_v;

  assign ram_we    = accept && do_store;
  assign ram_waddr = fill_v[AW-1:0];
  assign ram_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      esc_r        <= 1'b0;
      inside_r     <= 1'b0;
      close_wait_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      esc_r        <= esc_nxt;
      inside_r     <= inside_nxt;
      close_wait_r <= close_wait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sefr_back.sv =====
`default_nettype none
module sefr_back #(
  parameter int FRAME_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cq_empty,
  input  wire sefr_pkg::cmd_t                   cq_cmd,
  input  wire logic [$clog2(FRAME_DEPTH+1)-1:0] cq_len,
  output logic                                  cq_pop,
  output logic      [$clog2(FRAME_DEPTH)-1:0]   ram_raddr,
  input  wire logic [7:0]                       ram_rdata,
  output logic                                  of_push,
  output sefr_pkg::res_t                        of_data,
  input  wire logic                             of_full,
  output sefr_pkg::back_stat_t                  bstat
);

  import sefr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  back_state_t   state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic          zero_r, zero_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [CW-1:0] len_m1;

  assign len_m1    = cq_len - CW'(1);
  assign ram_raddr = idx_r;

  // next state
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    last_nxt    = last_r;
    zero_nxt    = zero_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    case (state_r)
      S_IDLE: begin
        if (!cq_empty) begin
          op_nxt      = cq_cmd.op;
          last_nxt    = len_m1[AW-1:0];
          zero_nxt    = (cq_len == '0);
          state_nxt   = cq_cmd.pre_nak ? S_PRE : S_ACT;
        end
      end
      S_PRE: begin
        if (!of_full) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        case (op_r)
          OP_ACK: begin
            if (!of_full) begin
              state_nxt = S_IDLE;
            end
          end
          OP_CLOSE: begin
            if (zero_r) begin
              state_nxt = S_NAK;
            end else begin
              idx_nxt   = '0;
              sum_nxt   = '0;
              state_nxt = S_SUM_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SUM_RD: state_nxt = S_SUM_AC;
      S_SUM_AC: begin
        // the last stored byte is the checksum
        if (idx_r == last_r) begin
          if (sum_r != ram_rdata) begin
            state_nxt = S_NAK;
          end else if (last_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_OUT_RD;
          end
        end else begin
          sum_nxt   = sum_r + ram_rdata;
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SUM_RD;
        end
      end
      S_NAK: begin
        if (!of_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_WR;
      S_OUT_WR: begin
        if (!of_full) begin
          if (idx_r == last_r - AW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cq_pop       = 1'b0;
    of_push      = 1'b0;
    of_data.kind = KIND_REPLY;
    of_data.data = CODE_NAK;
    of_data.last = 1'b1;
    case (state_r)
      S_IDLE: cq_pop = !cq_empty;
      S_PRE: of_push = !of_full;
      S_ACT: begin
        if (op_r == OP_ACK) begin
          of_push      = !of_full;
          of_data.data = CODE_ACK;
        end
      end
      S_NAK: of_push = !of_full;
      S_OUT_WR: begin
        of_push      = !of_full;
        of_data.kind = KIND_PAYLOAD;
        of_data.data = ram_rdata;
        of_data.last = (idx_r == last_r - AW'(1));
      end
      default: of_push = 1'b0;
    endcase
    bstat.close_done = (op_r == OP_CLOSE) && (state_r != S_IDLE) && (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_NONE;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    zero_r <= zero_nxt;
    idx_r  <= idx_nxt;
    sum_r  <= sum_nxt;
  end

endmodule
`default_nettype wire

// ===== src/stx_etx_frame_receiver.sv =====
// channel  | ports                              | transfer when
// ---------+------------------------------------+---------------------
// input    | push, full, in_rx_byte             | push && !full
// result   | empty, pop, out_kind/byte/last     | pop && !empty
//
// the front stores an ordinary byte and hands replies to a two-entry command
// queue, so it keeps taking bytes while replies wait, until that queue fills.
// a closing ETX holds full until the back is done: a read and a sum step per
// stored byte for the checksum pass, then a read and a write step per payload
// byte out, via the one registered buffer read port; longer if pop stalls.
// reset is synchronous; the frame buffer is not cleared and needs no pass.
`default_nettype none
module stx_etx_frame_receiver #(
  parameter int FRAME_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_kind,
  output logic      [7:0] out_byte,
  output logic            out_last
);

  import sefr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int QW = CW + $bits(cmd_t);

  cmd_t          f_cmd, b_cmd;
  logic [CW-1:0] f_len, b_len;
  logic          cq_push, cq_full, cq_pop, cq_empty;
  logic [QW-1:0] cq_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          of_push, of_full;
  res_t          of_wdata, of_rdata;
  back_stat_t    bstat;

  sefr_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .rx_byte   (in_rx_byte),
    .cq_push   (cq_push),
    .cq_cmd    (f_cmd),
    .cq_len    (f_len),
    .cq_full   (cq_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .bstat     (bstat)
  );

  sefr_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata ({f_cmd, f_len}),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  assign b_cmd = cq_rdata[QW-1:CW];
  assign b_len = cq_rdata[CW-1:0];

  sefr_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sefr_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_empty  (cq_empty),
    .cq_cmd    (b_cmd),
    .cq_len    (b_len),
    .cq_pop    (cq_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .of_push   (of_push),
    .of_data   (of_wdata),
    .of_full   (of_full),
    .bstat     (bstat)
  );

  sefr_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (of_push),
    .wdata (of_wdata),
    .full  (of_full),
    .pop   (pop),
    .rdata (of_rdata),
    .empty (empty)
  );

  assign out_kind = of_rdata.kind;
  assign out_byte = of_rdata.data;
  assign out_last = of_rdata.last;

endmodule
`default_nettype wire

// ===== src/sefr_checker.sv =====
`default_nettype none
module sefr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       push,
  input wire logic       full,
  input wire logic [7:0] in_rx_byte,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  import sefr_pkg::*;

  // nothing waits on the result side right after a reset edge
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result waiting right after reset");

  // a waiting result that is not taken stays put
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_byte) &&
                          $stable(out_last)))
    else $error("waiting result changed before transfer");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_REPLY)) |-> out_last)
    else $error("reply without last mark");

  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_REPLY)) |-> ((out_byte == CODE_ACK) ||
                                              (out_byte == CODE_NAK)))
    else $error("reply byte is neither ACK nor NAK");

  a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |-> !$isunknown(in_rx_byte))
    else $error("unknown byte on input transfer");

endmodule

bind stx_etx_frame_receiver sefr_checker u_chk (.*);
`default_nettype wire
